[design/page_fault_frame_replacer_core_assert.svh]
// Assertion macros for the page fault frame replacer.
// Each macro checks a property on the rising edge of clock, disabled during reset.
`ifndef PAGE_FAULT_FRAME_REPLACER_CORE_ASSERT_SVH
`define PAGE_FAULT_FRAME_REPLACER_CORE_ASSERT_SVH

`ifndef SYNTH
`define PFFR_ASSERT_SAME(label, ante, cons, msg) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
   else $error(msg);
`define PFFR_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
   else $error(msg);
`else
`define PFFR_ASSERT_SAME(label, ante, cons, msg)
`define PFFR_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[design/pffr_pkg.sv]
`timescale 1ns / 1ps
package pffr_pkg;

   localparam int PAGES_DEFAULT  = 256;
   localparam int FRAMES_DEFAULT = 16;

   localparam int PAGE_FIELD_W   = 8;
   localparam int FRAME_FIELD_W  = 4;
   localparam int ACT_W          = 3;
   localparam int RSP_DATA_W     = 16;
   localparam int POLICY_W       = 2;
   localparam int FIU_W          = 5;
   localparam int CSR_IDX_W      = 1;
   localparam int CSR_DATA_W     = 5;
   localparam int LFSR_W         = 16;

   localparam logic [LFSR_W-1:0]   LFSR_SEED           = 16'hACE1;
   localparam logic [POLICY_W-1:0] POLICY_RESET        = 2'd1;
   localparam logic [FIU_W-1:0]    FRAMES_IN_USE_RESET = 5'd16;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY_MODE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_IN_USE = 1'd1;

   localparam logic [POLICY_W-1:0] POLICY_RANDOM = 2'd0;
   localparam logic [POLICY_W-1:0] POLICY_FIFO   = 2'd1;
   localparam logic [POLICY_W-1:0] POLICY_DIRTY  = 2'd2;

   localparam logic [ACT_W-1:0] ACT_LOAD  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_GRANT = 3'd1;
   localparam logic [ACT_W-1:0] ACT_EVICT = 3'd2;
   localparam logic [ACT_W-1:0] ACT_NONE  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_ERROR = 3'd4;

   localparam logic [1:0] PERM_NONE = 2'd0;
   localparam logic [1:0] PERM_READ = 2'd1;
   localparam logic [1:0] PERM_RW   = 2'd3;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PT_LOOK,
      ST_FREE_SCAN,
      ST_DIRTY_FRAME,
      ST_DIRTY_OWNER,
      ST_DIRTY_PERM,
      ST_DRAW_WAIT,
      ST_EVICT_READ,
      ST_EVICT_OWNER,
      ST_EVICT_MAP,
      ST_RESP
   } pffr_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } pffr_rem_stat_type;

   function automatic logic [RSP_DATA_W-1:0] pack_rsp(
      input logic [ACT_W-1:0]         act,
      input logic [FRAME_FIELD_W-1:0] frame,
      input logic [PAGE_FIELD_W-1:0]  victim,
      input logic                     rd
   );
      pack_rsp = {rd, victim, frame, act};
   endfunction

endpackage

[design/pffr_rem_unit.sv]
`timescale 1ns / 1ps
module pffr_rem_unit #(
   parameter int DIV_W = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pffr_pkg::LFSR_W-1:0]   dividend,
   input  logic [DIV_W-1:0]              divisor,
   output pffr_pkg::pffr_rem_stat_type   stat,
   output logic [DIV_W-1:0]              remainder
);
   import pffr_pkg::*;

   localparam int STEP_W = $clog2(LFSR_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [LFSR_W-1:0] dvd_ff, dvd_in;
   logic [DIV_W-1:0]  div_ff, div_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W:0]    trial;
   logic [DIV_W:0]    diff;

   // Restoring remainder, one dividend bit per cycle, MSB first.
   always_comb begin
      trial   = {rem_ff, dvd_ff[LFSR_W-1]};
      diff    = trial - {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = (trial >= {1'b0, div_ff}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         dvd_in = {dvd_ff[LFSR_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(LFSR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign remainder = rem_ff;

endmodule

[design/page_fault_frame_replacer_core.sv]
`timescale 1ns / 1ps
// One page fault at a time: ready is low from acceptance until the response is registered
// and any held response is taken, so the next fault can enter only once that has happened.
// Outcomes: out-of-range page error, write grant or no-op, load into the first free frame;
// with all n frames full, fifo eviction, random eviction (16-step remainder unit), or
// dirty-first, which checks the frames in order (all n when none is read-write, then random).
// Synchronous reset clears control, then a pass over max(PAGES, FRAMES) entries empties the tables.
`include "page_fault_frame_replacer_core_assert.svh"
module page_fault_frame_replacer_core #(
   parameter int PAGES  = pffr_pkg::PAGES_DEFAULT,
   parameter int FRAMES = pffr_pkg::FRAMES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] fault_page
   input  logic [pffr_pkg::PAGE_FIELD_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [2:0] action, [6:3] frame_used, [14:7] victim_page, [15] read_from_disk
   output logic [pffr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [pffr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pffr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pffr_pkg::*;

   localparam int PAGE_W    = $clog2(PAGES);
   localparam int FRAME_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNT_W     = $clog2(FRAMES + 1);
   localparam int CLR_DEPTH = (PAGES > FRAMES) ? PAGES : FRAMES;
   localparam int CLR_W     = $clog2(CLR_DEPTH);

   typedef struct packed {
      logic [1:0]         perm;
      logic [FRAME_W-1:0] frame;
   } pt_entry_type;

   typedef struct packed {
      logic              occ;
      logic [PAGE_W-1:0] owner;
   } ft_entry_type;

   pt_entry_type page_tbl_mem [PAGES];
   ft_entry_type frame_tbl_mem [FRAMES];

   pffr_state_type      state_ff, state_in;
   logic [CLR_W-1:0]    clr_ff, clr_in;
   logic [PAGE_W-1:0]   page_ff, page_in;
   logic [CNT_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [FRAME_W-1:0]  victim_ff, victim_in;
   logic [PAGE_W-1:0]   vpage_ff, vpage_in;
   logic [FRAME_W-1:0]  rot_ff, rot_in;
   logic [LFSR_W-1:0]   lfsr_ff, lfsr_in;
   logic [RSP_DATA_W-1:0] res_data_ff, res_data_in;
   logic [POLICY_W-1:0] policy_ff, policy_in;
   logic [FIU_W-1:0]    fiu_ff, fiu_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic                pt_we;
   logic [PAGE_W-1:0]   pt_waddr, pt_raddr;
   pt_entry_type        pt_wdata, pt_rd_ff;
   logic                ft_we;
   logic [FRAME_W-1:0]  ft_waddr, ft_raddr;
   ft_entry_type        ft_wdata, ft_rd_ff;

   logic [CNT_W-1:0]    n_frames, n_last, chk_idx;
   logic [FRAME_W-1:0]  fifo_victim, fifo_next;
   logic [LFSR_W-1:0]   lfsr_step;
   logic                begin_draw;
   logic                rem_start;
   logic [CNT_W-1:0]    rem_result;
   pffr_rem_stat_type   rem_stat;

   pffr_rem_unit #(
      .DIV_W(CNT_W)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (lfsr_step),
      .divisor   (n_frames),
      .stat      (rem_stat),
      .remainder (rem_result)
   );

   // Clamp the frame count into 1..FRAMES.
   always_comb begin
      if (fiu_ff == '0) begin
         n_frames = CNT_W'(1);
      end else if (32'(fiu_ff) > FRAMES) begin
         n_frames = CNT_W'(FRAMES);
      end else begin
         n_frames = CNT_W'(fiu_ff);
      end
   end

   assign n_last  = n_frames - 1'b1;
   assign chk_idx = scan_idx_ff - 1'b1;

   assign lfsr_step = {lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5],
                       lfsr_ff[LFSR_W-1:1]};

   assign fifo_victim = (CNT_W'(rot_ff) < n_frames) ? rot_ff : '0;
   assign fifo_next   = ((CNT_W'(fifo_victim) + 1'b1) == n_frames) ?
                        '0 : fifo_victim + 1'b1;

   always_comb begin
      policy_in = policy_ff;
      fiu_in    = fiu_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_POLICY_MODE:   policy_in = csr_wdata[POLICY_W-1:0];
            CSR_FRAMES_IN_USE: fiu_in    = csr_wdata[FIU_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      page_in       = page_ff;
      scan_idx_in   = scan_idx_ff;
      victim_in     = victim_ff;
      vpage_in      = vpage_ff;
      rot_in        = rot_ff;
      lfsr_in       = lfsr_ff;
      res_data_in   = res_data_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      req_tready    = 1'b0;
      begin_draw    = 1'b0;
      rem_start     = 1'b0;
      pt_we         = 1'b0;
      pt_waddr      = page_ff;
      pt_wdata      = '{perm: PERM_NONE, frame: '0};
      pt_raddr      = page_ff;
      ft_we         = 1'b0;
      ft_waddr      = victim_ff;
      ft_wdata      = '{occ: 1'b0, owner: '0};
      ft_raddr      = scan_idx_ff[FRAME_W-1:0];

      case (state_ff)
         ST_CLEAR: begin
            pt_we    = (32'(clr_ff) < PAGES);
            pt_waddr = clr_ff[PAGE_W-1:0];
            ft_we    = (32'(clr_ff) < FRAMES);
            ft_waddr = clr_ff[FRAME_W-1:0];
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == CLR_W'(CLR_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            pt_raddr   = PAGE_W'(req_tdata);
            if (req_tvalid) begin
               page_in = PAGE_W'(req_tdata);
               if (32'(req_tdata) >= PAGES) begin
                  res_data_in = pack_rsp(ACT_ERROR, '0, '0, 1'b0);
                  state_in    = ST_RESP;
               end else begin
                  state_in = ST_PT_LOOK;
               end
            end
         end
         ST_PT_LOOK: begin
            case (pt_rd_ff.perm)
               PERM_READ: begin
                  pt_we       = 1'b1;
                  pt_wdata    = '{perm: PERM_RW, frame: pt_rd_ff.frame};
                  res_data_in = pack_rsp(ACT_GRANT, FRAME_FIELD_W'(pt_rd_ff.frame),
                                         '0, 1'b0);
                  state_in    = ST_RESP;
               end
               PERM_NONE: begin
                  scan_idx_in = '0;
                  state_in    = ST_FREE_SCAN;
               end
               default: begin
                  res_data_in = pack_rsp(ACT_NONE, FRAME_FIELD_W'(pt_rd_ff.frame),
                                         '0, 1'b0);
                  state_in    = ST_RESP;
               end
            endcase
         end
         ST_FREE_SCAN: begin
            // Issue a read each cycle and check the entry read the cycle before.
            scan_idx_in = scan_idx_ff + 1'b1;
            if (scan_idx_ff != '0) begin
               if (!ft_rd_ff.occ) begin
                  ft_we       = 1'b1;
                  ft_waddr    = chk_idx[FRAME_W-1:0];
                  ft_wdata    = '{occ: 1'b1, owner: page_ff};
                  pt_we       = 1'b1;
                  pt_wdata    = '{perm: PERM_READ, frame: chk_idx[FRAME_W-1:0]};
                  res_data_in = pack_rsp(ACT_LOAD, FRAME_FIELD_W'(chk_idx), '0, 1'b1);
                  state_in    = ST_RESP;
               end else if (chk_idx == n_last) begin
                  case (policy_ff)
                     POLICY_RANDOM: begin_draw = 1'b1;
                     POLICY_FIFO: begin
                        victim_in = fifo_victim;
                        rot_in    = fifo_next;
                        state_in  = ST_EVICT_READ;
                     end
                     POLICY_DIRTY: begin
                        scan_idx_in = '0;
                        state_in    = ST_DIRTY_FRAME;
                     end
                     default: begin
                        res_data_in = pack_rsp(ACT_ERROR, '0, '0, 1'b0);
                        state_in    = ST_RESP;
                     end
                  endcase
               end
            end
         end
         ST_DIRTY_FRAME: begin
            state_in = ST_DIRTY_OWNER;
         end
         ST_DIRTY_OWNER: begin
            pt_raddr = ft_rd_ff.owner;
            state_in = ST_DIRTY_PERM;
         end
         ST_DIRTY_PERM: begin
            if (pt_rd_ff.perm[1]) begin
               victim_in = scan_idx_ff[FRAME_W-1:0];
               state_in  = ST_EVICT_READ;
            end else if (scan_idx_ff == n_last) begin
               begin_draw = 1'b1;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
               state_in    = ST_DIRTY_FRAME;
            end
         end
         ST_DRAW_WAIT: begin
            if (rem_stat.done) begin
               victim_in = rem_result[FRAME_W-1:0];
               state_in  = ST_EVICT_READ;
            end
         end
         ST_EVICT_READ: begin
            ft_raddr = victim_ff;
            state_in = ST_EVICT_OWNER;
         end
         ST_EVICT_OWNER: begin
            // Unmap the old owner, hand the frame to the faulting page.
            vpage_in = ft_rd_ff.owner;
            pt_we    = 1'b1;
            pt_waddr = ft_rd_ff.owner;
            pt_wdata = '{perm: PERM_NONE, frame: '0};
            ft_we    = 1'b1;
            ft_waddr = victim_ff;
            ft_wdata = '{occ: 1'b1, owner: page_ff};
            state_in = ST_EVICT_MAP;
         end
         ST_EVICT_MAP: begin
            pt_we       = 1'b1;
            pt_wdata    = '{perm: PERM_READ, frame: victim_ff};
            res_data_in = pack_rsp(ACT_EVICT, FRAME_FIELD_W'(victim_ff),
                                   PAGE_FIELD_W'(vpage_ff), 1'b1);
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = res_data_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (begin_draw) begin
         lfsr_in   = lfsr_step;
         rem_start = 1'b1;
         state_in  = ST_DRAW_WAIT;
      end
   end

   always_ff @(posedge clock) begin
      if (pt_we) begin
         page_tbl_mem[pt_waddr] <= pt_wdata;
      end
      pt_rd_ff <= page_tbl_mem[pt_raddr];
   end

   always_ff @(posedge clock) begin
      if (ft_we) begin
         frame_tbl_mem[ft_waddr] <= ft_wdata;
      end
      ft_rd_ff <= frame_tbl_mem[ft_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         rot_ff        <= '0;
         lfsr_ff       <= LFSR_SEED;
         policy_ff     <= POLICY_RESET;
         fiu_ff        <= FRAMES_IN_USE_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rot_ff        <= rot_in;
         lfsr_ff       <= lfsr_in;
         policy_ff     <= policy_in;
         fiu_ff        <= fiu_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      page_ff      <= page_in;
      scan_idx_ff  <= scan_idx_in;
      victim_ff    <= victim_in;
      vpage_ff     <= vpage_in;
      res_data_ff  <= res_data_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   `PFFR_ASSERT_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready, "ready after fault")
   `PFFR_ASSERT_SAME(a_rsp_from_resp, $rose(rsp_tvalid), $past(state_ff == ST_RESP), "stray response")
   `PFFR_ASSERT_SAME(a_rem_in_draw, rem_stat.busy || rem_stat.done, state_ff == ST_DRAW_WAIT, "stray draw")

endmodule

[verif/page_fault_frame_replacer_checker.sv]
`timescale 1ns / 1ps
module page_fault_frame_replacer_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [pffr_pkg::PAGE_FIELD_W-1:0]   req_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [pffr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [pffr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pffr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                  fail_count,
   output int                                  outstanding
);
   import pffr_pkg::*;

   localparam int PAGES  = PAGES_DEFAULT;
   localparam int FRAMES = FRAMES_DEFAULT;

   // same bit order as rsp_tdata: disk flag on top, action at the bottom
   typedef struct packed {
      logic                     disk;
      logic [PAGE_FIELD_W-1:0]  victim;
      logic [FRAME_FIELD_W-1:0] frame;
      logic [ACT_W-1:0]         action;
   } fault_outcome_type;

   logic [FRAME_FIELD_W-1:0] page_frame  [PAGES];
   logic [1:0]               page_perm   [PAGES];
   logic [PAGE_FIELD_W-1:0]  frame_owner [FRAMES];
   logic                     frame_busy  [FRAMES];
   logic [FRAME_FIELD_W-1:0] rotation;
   logic [LFSR_W-1:0]        shift_reg;
   logic [POLICY_W-1:0]      policy;
   logic [FIU_W-1:0]         frame_limit;
   fault_outcome_type        pending_outcomes [$];

   function automatic int draw_victim(input int n);
      logic fb;
      fb = shift_reg[0] ^ shift_reg[2] ^ shift_reg[3] ^ shift_reg[5];
      shift_reg = {fb, shift_reg[LFSR_W-1:1]};
      return int'(shift_reg) % n;
   endfunction

   function automatic fault_outcome_type resolve_fault(input logic [PAGE_FIELD_W-1:0] page);
      fault_outcome_type res;
      int n;
      int i;
      int victim;
      logic rw_hit;
      logic [PAGE_FIELD_W-1:0] evicted;
      res = '0;
      n = int'(frame_limit);
      if (n < 1) n = 1;
      if (n > FRAMES) n = FRAMES;

      if (page_perm[page] == PERM_READ) begin
         page_perm[page] = PERM_RW;
         res.action = ACT_GRANT;
         res.frame  = page_frame[page];
         return res;
      end
      if (page_perm[page] != PERM_NONE) begin
         res.action = ACT_NONE;
         res.frame  = page_frame[page];
         return res;
      end

      for (i = 0; i < n; i++) begin
         if (!frame_busy[i]) begin
            frame_busy[i]    = 1'b1;
            frame_owner[i]   = page;
            page_frame[page] = FRAME_FIELD_W'(i);
            page_perm[page]  = PERM_READ;
            res.action = ACT_LOAD;
            res.frame  = FRAME_FIELD_W'(i);
            res.disk   = 1'b1;
            return res;
         end
      end

      victim = 0;
      case (policy)
         POLICY_RANDOM: victim = draw_victim(n);
         POLICY_FIFO: begin
            // a stale pointer past the active frames falls back to frame 0
            victim = (int'(rotation) < n) ? int'(rotation) : 0;
            rotation = FRAME_FIELD_W'((victim + 1) % n);
         end
         POLICY_DIRTY: begin
            rw_hit = 1'b0;
            for (i = 0; i < n && !rw_hit; i++) begin
               if (page_perm[frame_owner[i]] >= 2'd2) begin
                  victim = i;
                  rw_hit = 1'b1;
               end
            end
            if (!rw_hit) victim = draw_victim(n);
         end
         default: begin
            res.action = ACT_ERROR;
            return res;
         end
      endcase

      evicted = frame_owner[victim];
      page_perm[evicted]  = PERM_NONE;
      page_frame[evicted] = '0;
      frame_owner[victim] = page;
      frame_busy[victim]  = 1'b1;
      page_frame[page]    = FRAME_FIELD_W'(victim);
      page_perm[page]     = PERM_READ;
      res.action = ACT_EVICT;
      res.frame  = FRAME_FIELD_W'(victim);
      res.victim = evicted;
      res.disk   = 1'b1;
      return res;
   endfunction

   function automatic void check_field(input string field, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      fault_outcome_type want;
      fault_outcome_type got;
      if (reset) begin
         for (int p = 0; p < PAGES; p++) begin
            page_frame[p] = '0;
            page_perm[p]  = PERM_NONE;
         end
         for (int f = 0; f < FRAMES; f++) begin
            frame_owner[f] = '0;
            frame_busy[f]  = 1'b0;
         end
         rotation    = '0;
         shift_reg   = LFSR_SEED;
         policy      = POLICY_RESET;
         frame_limit = FRAMES_IN_USE_RESET;
         pending_outcomes.delete();
         fail_count  = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_POLICY_MODE) policy = csr_wdata[POLICY_W-1:0];
            else if (csr_index == CSR_FRAMES_IN_USE) frame_limit = csr_wdata[FIU_W-1:0];
         end
         if (req_tvalid && req_tready) pending_outcomes.push_back(resolve_fault(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = fault_outcome_type'(rsp_tdata);
            if (pending_outcomes.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, got %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = pending_outcomes.pop_front();
               check_field("action", 16'(want.action), 16'(got.action));
               check_field("frame_used", 16'(want.frame), 16'(got.frame));
               check_field("victim_page", 16'(want.victim), 16'(got.victim));
               check_field("read_from_disk", 16'(want.disk), 16'(got.disk));
            end
         end
      end
      outstanding <= pending_outcomes.size();
   end

endmodule

[verif/page_fault_frame_replacer_core_tb.sv]
`timescale 1ns / 1ps
module page_fault_frame_replacer_core_tb;
   import pffr_pkg::*;

   localparam logic [POLICY_W-1:0] POLICY_UNKNOWN = 2'd3;
   localparam int RANDOM_PHASES = 22;
   localparam int PHASE_FAULTS  = 25;
   localparam int DRAIN_CYCLES  = 64;
   localparam int CYCLE_LIMIT   = 400000;

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [PAGE_FIELD_W-1:0] req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index  = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;
   int                      fail_count;
   int                      outstanding;
   int                      send_idle_pct = 0;
   int                      rsp_stall_pct = 0;
   int                      cycle_count   = 0;

   page_fault_frame_replacer_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   page_fault_frame_replacer_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // keep valid high across back-to-back faults; only drop it for a gap
   task automatic send_fault(input logic [PAGE_FIELD_W-1:0] page);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= page;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic apply_config(input logic [POLICY_W-1:0] mode, input logic [FIU_W-1:0] frames);
      // hold off until every fault issued so far has been answered
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      csr_we    <= 1'b1;
      csr_index <= CSR_POLICY_MODE;
      csr_wdata <= CSR_DATA_W'(mode);
      @(posedge clock);
      csr_index <= CSR_FRAMES_IN_USE;
      csr_wdata <= CSR_DATA_W'(frames);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int n;
      int pick;
      logic [PAGE_FIELD_W-1:0] window_base;
      logic [POLICY_W-1:0]     mode;
      logic [FIU_W-1:0]        frames;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // two frames: load, load, grant, nothing, then two fifo evictions
      apply_config(POLICY_FIFO, 5'd2);
      send_fault(8'd0);
      send_fault(8'd255);
      send_fault(8'd0);
      send_fault(8'd0);
      send_fault(8'd128);
      send_fault(8'd1);
      // unknown policy: error when full, normal load when a frame is free
      apply_config(POLICY_UNKNOWN, 5'd2);
      send_fault(8'd9);
      send_fault(8'd128);
      apply_config(POLICY_UNKNOWN, 5'd3);
      send_fault(8'd9);
      // dirty-first: pick the read-write frame, then fall back to random
      apply_config(POLICY_DIRTY, 5'd3);
      send_fault(8'd20);
      send_fault(8'd21);
      // advance the rotation pointer, then shrink the frame count below it
      apply_config(POLICY_FIFO, 5'd3);
      send_fault(8'd50);
      send_fault(8'd51);
      apply_config(POLICY_FIFO, 5'd2);
      send_fault(8'd52);
      // zero frames acts as one
      apply_config(POLICY_RANDOM, 5'd0);
      send_fault(8'd30);
      send_fault(8'd31);
      // oversized frame count clamps to all frames
      apply_config(POLICY_FIFO, 5'd31);
      send_fault(8'd40);
      send_fault(8'd40);
      send_fault(8'd40);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         pick = $urandom_range(7);
         if (pick < 2) mode = POLICY_RANDOM;
         else if (pick < 5) mode = POLICY_FIFO;
         else if (pick < 7) mode = POLICY_DIRTY;
         else mode = POLICY_UNKNOWN;
         case ($urandom_range(9))
            0: frames = 5'd0;
            1: frames = 5'd1;
            2: frames = 5'd16;
            3: frames = 5'd17;
            4: frames = 5'd31;
            default: frames = FIU_W'($urandom_range(2, 15));
         endcase
         n = (frames == 0) ? 1 : ((frames > FRAMES_DEFAULT) ? FRAMES_DEFAULT : int'(frames));
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 70; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 70; end
            default: begin send_idle_pct = 17; rsp_stall_pct = 17; end
         endcase
         apply_config(mode, frames);
         window_base = PAGE_FIELD_W'($urandom_range(255));
         // mostly a working set about twice the size of the frame pool, so pages
         // cycle through load, grant and eviction; the rest spans all pages
         for (int k = 0; k < PHASE_FAULTS; k++) begin
            if ($urandom_range(99) < 80)
               send_fault(window_base + PAGE_FIELD_W'($urandom_range(2 * n)));
            else
               send_fault(PAGE_FIELD_W'($urandom_range(255)));
         end
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
